@@ sv/sthm_pkg.sv @@
`timescale 1ns / 1ps
// Package for the four-motor half-step sequencer: widths, codes, record types
// and the half-step coil table. No dependencies.
package sthm_pkg;

   localparam int NUM_MOTORS = 4;
   localparam int MAX_MOVE   = 10000;
   localparam int MOTOR_W    = 2;
   localparam int MOTOR_CNT  = 2 ** MOTOR_W;
   localparam int POS_W      = 16;
   localparam int PHASE_W    = 3;
   localparam int COIL_W     = 4;
   localparam int CNT_W      = $clog2(MAX_MOVE + 1);
   localparam int NUM_CFG    = 2 * MOTOR_CNT;
   localparam int CFG_IDX_W  = $clog2(NUM_CFG);
   localparam int CFG_W      = 16;

   typedef enum logic [1:0] {
      KIND_MOVE    = 2'd0,
      KIND_TICK    = 2'd1,
      KIND_RELEASE = 2'd2,
      KIND_SPARE   = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED = 3'd0,
      ST_LIMIT    = 3'd1,
      ST_RANGE    = 3'd2,
      ST_BUSY     = 3'd3,
      ST_STEPPED  = 3'd4,
      ST_IDLE     = 3'd5,
      ST_RELEASED = 3'd6
   } status_type;

   // One per-motor entry of the state memory
   typedef struct packed {
      logic signed [POS_W-1:0] position;
      logic [PHASE_W-1:0]      phase;
      logic [COIL_W-1:0]       coils;
   } motor_rec_type;

   localparam int REC_W = $bits(motor_rec_type);

   // Soft limit window of one motor
   typedef struct packed {
      logic signed [CFG_W-1:0] lo;
      logic signed [CFG_W-1:0] hi;
   } window_type;

   localparam logic [CFG_W-1:0] CFG_RESET [NUM_CFG] = '{
      16'hFC18, 16'd1000, 16'hFC18, 16'd1000,
      16'd0, 16'd2048, 16'd0, 16'd4096
   };

   function automatic logic [COIL_W-1:0] coil_pattern(input logic [PHASE_W-1:0] phase);
      logic [COIL_W-1:0] pat;
      unique case (phase)
         3'd0: pat = 4'h1;
         3'd1: pat = 4'h3;
         3'd2: pat = 4'h2;
         3'd3: pat = 4'h6;
         3'd4: pat = 4'h4;
         3'd5: pat = 4'hC;
         3'd6: pat = 4'h8;
         3'd7: pat = 4'h9;
         default: pat = '0;
      endcase
      return pat;
   endfunction

endpackage

@@ sv/sthm_req_if.sv @@
`timescale 1ns / 1ps
// Request channel of the sequencer: valid/ready plus one command item.
// Depends on sthm_pkg.
interface sthm_req_if;
   import sthm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [1:0]              kind;
   logic [MOTOR_W-1:0]      motor;
   logic signed [CFG_W-1:0] steps;

   modport source (output valid, output kind, output motor, output steps, input ready);
   modport sink   (input valid, input kind, input motor, input steps, output ready);
endinterface

@@ sv/sthm_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel of the sequencer: valid/ready plus one status item.
// Depends on sthm_pkg.
interface sthm_rsp_if;
   import sthm_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [2:0]              status;
   logic [MOTOR_W-1:0]      motor_out;
   logic [COIL_W-1:0]       coils;
   logic signed [POS_W-1:0] position;
   logic                    done_res;

   modport source (output valid, output status, output motor_out, output coils,
                   output position, output done_res, input ready);
   modport sink   (input valid, input status, input motor_out, input coils,
                   input position, input done_res, output ready);
endinterface

@@ sv/stepper_half_step_limited_mover.sv @@
`timescale 1ns / 1ps
// Top level of the four-motor half-step sequencer with soft position limits.
// Depends on sthm_pkg, sthm_req_if, sthm_rsp_if, sthm_ram and sthm_cfg.
//
//   channel   direction  handshake      carries
//   req_chan  in         valid/ready    kind, motor, steps
//   rsp_chan  out        valid/ready    status, motor_out, coils, position, done_res
//   csr_*     in         write enable   limit register index and value
//
// One item per cycle sustained while the response is not stalled. Acceptance loads
// the state memory read register and the execute stage; the item then moves into the
// response register, which offers it on rsp_chan, once that register is free.
// Reset clears the move control, the memory valid bits and both pipeline stages,
// and holds off the input; unwritten memory entries read as zero.
// A stalled response holds the item in the execute stage; a new item is taken in
// the same cycle the response register drains.
module stepper_half_step_limited_mover (
   input  logic                           clock,
   input  logic                           reset,
   sthm_req_if.sink                       req_chan,
   sthm_rsp_if.source                     rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [sthm_pkg::CFG_IDX_W-1:0] csr_index,
   input  logic [sthm_pkg::CFG_W-1:0]     csr_wdata
);
   import sthm_pkg::*;

   // ---------------------------------------------------------------------------
   // Move control registers
   // ---------------------------------------------------------------------------
   logic               busy_ff, busy_in;
   logic [MOTOR_W-1:0] active_ff, active_in;
   logic               reverse_ff, reverse_in;
   logic [CNT_W-1:0]   left_ff, left_in;

   // Execute stage (item whose memory read is under way)
   logic                    s1_valid_ff;
   kind_type                s1_kind_ff;
   logic [MOTOR_W-1:0]      s1_motor_ff;
   logic [MOTOR_W-1:0]      s1_addr_ff;
   logic signed [CFG_W-1:0] s1_steps_ff;
   logic                    fwd_ff;
   motor_rec_type           fwd_rec_ff;

   // Memory entry valid bits
   logic [MOTOR_CNT-1:0] vld_ff;

   // Response register
   logic                    out_valid_ff;
   status_type              out_status_ff, out_status_in;
   logic [MOTOR_W-1:0]      out_motor_ff, out_motor_in;
   logic [COIL_W-1:0]       out_coils_ff, out_coils_in;
   logic signed [POS_W-1:0] out_pos_ff, out_pos_in;
   logic                    out_done_ff, out_done_in;

   logic               out_free, s1_adv, accept;
   logic [MOTOR_W-1:0] rd_addr;
   logic [REC_W-1:0]   rd_data;
   motor_rec_type      cur_rec, new_rec;
   logic               wr_req, wr_en;
   window_type         window;

   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && out_free;
   assign req_chan.ready = !reset && (!s1_valid_ff || out_free);
   assign accept         = req_chan.valid && req_chan.ready;
   assign wr_en          = s1_adv && wr_req;

   // ---------------------------------------------------------------------------
   // State memory and limit registers
   // ---------------------------------------------------------------------------
   sthm_ram #(
      .WIDTH (REC_W),
      .DEPTH (MOTOR_CNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (new_rec),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sthm_cfg u_cfg (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_wr_en),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .rd_motor (s1_motor_ff),
      .window   (window)
   );

   // Address the moving motor for a tick while a move is armed, as it will
   // stand once the item in the execute stage has finished.
   always_comb begin
      if (kind_type'(req_chan.kind) == KIND_TICK && busy_in) begin
         rd_addr = active_in;
      end else begin
         rd_addr = req_chan.motor;
      end
   end

   // ---------------------------------------------------------------------------
   // Execute: read-modify-write of the addressed motor entry
   // ---------------------------------------------------------------------------
   logic [CFG_W:0]         steps_x, mag;
   logic signed [CFG_W+1:0] target, lo_x, hi_x;
   logic                   motor_ok, rep_ok;
   logic [MOTOR_W-1:0]     rep_motor;

   always_comb begin
      // Take the entry from the write just made to the same motor, if any
      if (fwd_ff) begin
         cur_rec = fwd_rec_ff;
      end else if (vld_ff[s1_addr_ff]) begin
         cur_rec = motor_rec_type'(rd_data);
      end else begin
         cur_rec = '0;
      end

      steps_x  = {s1_steps_ff[CFG_W-1], s1_steps_ff};
      mag      = s1_steps_ff[CFG_W-1] ? ((CFG_W+1)'(0) - steps_x) : steps_x;
      target   = (CFG_W+2)'(cur_rec.position) + (CFG_W+2)'(s1_steps_ff);
      lo_x     = (CFG_W+2)'(window.lo);
      hi_x     = (CFG_W+2)'(window.hi);
      motor_ok = {1'b0, s1_motor_ff} < (MOTOR_W+1)'(NUM_MOTORS);

      new_rec       = cur_rec;
      wr_req        = 1'b0;
      busy_in       = busy_ff;
      active_in     = active_ff;
      reverse_in    = reverse_ff;
      left_in       = left_ff;
      out_status_in = ST_IDLE;
      out_done_in   = 1'b0;
      rep_motor     = s1_motor_ff;

      if (s1_valid_ff) begin
         priority if (s1_kind_ff == KIND_TICK && busy_ff) begin
            // Drive the current phase, then advance phase, position and count
            new_rec.coils = coil_pattern(cur_rec.phase);
            if (reverse_ff) begin
               new_rec.phase    = cur_rec.phase - PHASE_W'(1);
               new_rec.position = cur_rec.position - POS_W'(1);
            end else begin
               new_rec.phase    = cur_rec.phase + PHASE_W'(1);
               new_rec.position = cur_rec.position + POS_W'(1);
            end
            wr_req    = 1'b1;
            left_in   = left_ff - CNT_W'(1);
            rep_motor = active_ff;
            out_status_in = ST_STEPPED;
            if (left_ff == CNT_W'(1)) begin
               busy_in     = 1'b0;
               out_done_in = 1'b1;
            end
         end else if (s1_kind_ff == KIND_TICK || s1_kind_ff == KIND_SPARE) begin
            out_status_in = ST_IDLE;
         end else if (busy_ff) begin
            out_status_in = ST_BUSY;
         end else if (s1_kind_ff == KIND_RELEASE) begin
            out_status_in = ST_RELEASED;
            if (motor_ok) begin
               new_rec.coils = '0;
               wr_req        = 1'b1;
            end
         end else if (mag > (CFG_W+1)'(MAX_MOVE)) begin
            out_status_in = ST_RANGE;
         end else if (!motor_ok || target < lo_x || target > hi_x) begin
            out_status_in = ST_LIMIT;
         end else if (mag == '0) begin
            // Zero-length move completes at once
            out_status_in = ST_ACCEPTED;
            out_done_in   = 1'b1;
         end else begin
            out_status_in = ST_ACCEPTED;
            busy_in       = 1'b1;
            active_in     = s1_motor_ff;
            reverse_in    = s1_steps_ff[CFG_W-1];
            left_in       = mag[CNT_W-1:0];
         end
      end

      rep_ok       = {1'b0, rep_motor} < (MOTOR_W+1)'(NUM_MOTORS);
      out_motor_in = rep_motor;
      out_coils_in = rep_ok ? new_rec.coils : '0;
      out_pos_in   = rep_ok ? new_rec.position : '0;
   end

   // ---------------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         active_ff    <= '0;
         reverse_ff   <= 1'b0;
         left_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         fwd_ff       <= 1'b0;
         vld_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            busy_ff    <= busy_in;
            active_ff  <= active_in;
            reverse_ff <= reverse_in;
            left_ff    <= left_in;
         end
         if (wr_en) begin
            vld_ff[s1_addr_ff] <= 1'b1;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
            fwd_ff      <= wr_en && (s1_addr_ff == rd_addr);
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers: hold unless a new item enters
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff  <= kind_type'(req_chan.kind);
         s1_motor_ff <= req_chan.motor;
         s1_addr_ff  <= rd_addr;
         s1_steps_ff <= req_chan.steps;
         fwd_rec_ff  <= new_rec;
      end
      if (s1_adv) begin
         out_status_ff <= out_status_in;
         out_motor_ff  <= out_motor_in;
         out_coils_ff  <= out_coils_in;
         out_pos_ff    <= out_pos_in;
         out_done_ff   <= out_done_in;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.status    = out_status_ff;
   assign rsp_chan.motor_out = out_motor_ff;
   assign rsp_chan.coils     = out_coils_ff;
   assign rsp_chan.position  = out_pos_ff;
   assign rsp_chan.done_res  = out_done_ff;
endmodule

@@ sv/sthm_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sthm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

@@ sv/sthm_cfg.sv @@
`timescale 1ns / 1ps
// Soft limit register file: one min/max pair per motor, written by index.
// Depends on sthm_pkg.
module sthm_cfg (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            wr_en,
   input  logic [sthm_pkg::CFG_IDX_W-1:0]  wr_index,
   input  logic [sthm_pkg::CFG_W-1:0]      wr_data,
   input  logic [sthm_pkg::MOTOR_W-1:0]    rd_motor,
   output sthm_pkg::window_type            window
);
   import sthm_pkg::*;

   logic [CFG_W-1:0] min_ff [MOTOR_CNT];
   logic [CFG_W-1:0] max_ff [MOTOR_CNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MOTOR_CNT; i++) begin
            min_ff[i] <= CFG_RESET[2*i];
            max_ff[i] <= CFG_RESET[2*i+1];
         end
      end else if (wr_en) begin
         // Even index holds the lower bound, odd the upper
         if (wr_index[0]) begin
            max_ff[wr_index[CFG_IDX_W-1:1]] <= wr_data;
         end else begin
            min_ff[wr_index[CFG_IDX_W-1:1]] <= wr_data;
         end
      end
   end

   assign window.lo = $signed(min_ff[rd_motor]);
   assign window.hi = $signed(max_ff[rd_motor]);
endmodule
